### rtl/qam_slicer_diff_descrambler_unit_assert.svh
// Assertion macros shared by the slicer / descrambler RTL.
`ifndef QAM_SLICER_DIFF_DESCRAMBLER_UNIT_ASSERT_SVH
`define QAM_SLICER_DIFF_DESCRAMBLER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define QSDD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define QSDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/qsdd_pkg.sv
// Shared types, constants and helper functions for the QAM slicer / descrambler.
`timescale 1ns / 1ps
`default_nettype none

package qsdd_pkg;

    // Rate mode codes
    localparam logic [1:0] RATE_4800 = 2'd0;
    localparam logic [1:0] RATE_7200 = 2'd1;
    localparam logic [1:0] RATE_9600 = 2'd2;

    // Slicer grid: 50 cells per axis, cell i centered at (2i-49)/10
    localparam logic [5:0]         CELL_MAX    = 6'd49;
    localparam logic signed [12:0] CELL_SHIFT  = 13'sd1280; // offset of 5.0 in Q4.8
    localparam logic signed [7:0]  CENTER_OFFS = 8'sd49;

    // Descrambler taps (x^-18 and x^-23) and history length
    localparam int HIST_W = 23;
    localparam int TAP_A  = 17;
    localparam int TAP_B  = 22;

    // Request payloads
    typedef struct packed {
        logic signed [11:0] symbol_re;
        logic signed [11:0] symbol_im;
        logic               deliver;
    } t_in_item;

    typedef struct packed {
        logic data_bit;
        logic last_bit;
    } t_out_item;

    // Cell center in tenths, and nearest-point score
    typedef logic signed [6:0] t_coord;
    typedef logic signed [9:0] t_score;

    // Slicer -> decoder
    typedef struct packed {
        logic [3:0] point16;
        logic [1:0] point4;
        logic       deliver;
    } t_slice;

    // Decoder -> serializer: left-aligned bits, MSB goes out first
    typedef struct packed {
        logic [3:0] bits;
        logic [2:0] count;
    } t_bits;

    // 16-point constellation
    localparam logic signed [3:0] PT_RE [16] =
        '{4'sd3, 4'sd1, 4'sd0, -4'sd1, -4'sd3, -4'sd1, 4'sd0, 4'sd1,
          4'sd5, 4'sd3, 4'sd0, -4'sd3, -4'sd5, -4'sd3, 4'sd0, 4'sd3};
    localparam logic signed [3:0] PT_IM [16] =
        '{4'sd0, 4'sd1, 4'sd3, 4'sd1, 4'sd0, -4'sd1, -4'sd3, -4'sd1,
          4'sd0, 4'sd3, 4'sd5, 4'sd3, 4'sd0, -4'sd3, -4'sd5, -4'sd3};
    // 5 * |p|^2 per point
    localparam t_score PT_R2X5 [16] =
        '{10'sd45, 10'sd10, 10'sd45, 10'sd10, 10'sd45, 10'sd10, 10'sd45, 10'sd10,
          10'sd125, 10'sd90, 10'sd125, 10'sd90, 10'sd125, 10'sd90, 10'sd125, 10'sd90};

    // Phase step Gray tables
    localparam logic [2:0] GRAY8 [8] = '{3'd1, 3'd0, 3'd2, 3'd3, 3'd7, 3'd6, 3'd4, 3'd5};
    localparam logic [1:0] GRAY4 [4] = '{2'd0, 2'd1, 2'd3, 2'd2};

    // floor((v+5)*5) clamped to 0..49, returned as cell center 2*cell-49
    function automatic t_coord cell_center(input logic signed [11:0] raw);
        logic signed [12:0] shifted;
        logic signed [15:0] scaled;
        logic [5:0]         grid_idx;
        shifted = 13'(raw) + CELL_SHIFT;
        scaled  = (16'(shifted) <<< 2) + 16'(shifted);
        if (scaled[15]) begin
            grid_idx = '0;
        end else if (scaled[14:8] > 7'(CELL_MAX)) begin
            grid_idx = CELL_MAX;
        end else begin
            grid_idx = scaled[13:8];
        end
        return t_coord'($signed({1'b0, grid_idx, 1'b0}) - CENTER_OFFS);
    endfunction

    // Squared distance to point k, less the common x^2+y^2 term, divided by 20
    function automatic t_score point_score(input logic [3:0] k, input t_coord x,
                                           input t_coord y);
        t_score ax;
        t_score by;
        ax = 10'(PT_RE[k]) * 10'(x);
        by = 10'(PT_IM[k]) * 10'(y);
        return PT_R2X5[k] - ax - by;
    endfunction

endpackage

`default_nettype wire

### rtl/qsdd_slicer.sv
// Three-stage slicer: grid cell, per-point scores, nearest-point tree.
`timescale 1ns / 1ps
`default_nettype none

module qsdd_slicer import qsdd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_valid,
    input  logic     i_ready,
    output t_slice   o_slice
);

    // stage 1: cell centers and quadrant decision
    logic       r_v1;
    t_coord     r_x;
    t_coord     r_y;
    logic [1:0] r_q1;
    logic       r_d1;
    t_coord     n_x;
    t_coord     n_y;
    logic [1:0] n_q1;
    // stage 2: scores
    logic       r_v2;
    t_score     r_score [16];
    t_score     n_score [16];
    logic [1:0] r_q2;
    logic       r_d2;
    // stage 3: chosen point
    logic       r_v3;
    t_slice     r_slice;
    t_slice     n_slice;
    // comparison tree
    t_score     s8 [8];
    logic [3:0] i8 [8];
    t_score     s4 [4];
    logic [3:0] i4 [4];
    t_score     s2 [2];
    logic [3:0] i2 [2];
    logic [3:0] best;
    logic       load1;
    logic       load2;
    logic       load3;
    logic       b1;
    logic       b2;
    logic signed [12:0] diag_sum;

    // pipeline advance
    assign load3   = !r_v3 || i_ready;
    assign load2   = !r_v2 || load3;
    assign load1   = !r_v1 || load2;
    assign o_ready = load1;
    assign o_valid = r_v3;
    assign o_slice = r_slice;

    // stage 1 logic: quadrant from the two diagonals (4800)
    always_comb begin
        n_x      = cell_center(i_item.symbol_re);
        n_y      = cell_center(i_item.symbol_im);
        diag_sum = 13'(i_item.symbol_re) + 13'(i_item.symbol_im);
        b1       = i_item.symbol_im > i_item.symbol_re;
        b2       = diag_sum[12];
        n_q1     = {b2, b1 ^ b2};
    end

    // stage 2 logic: one score per constellation point
    always_comb begin
        for (int k = 0; k < 16; k++) begin
            n_score[k] = point_score(4'(k), r_x, r_y);
        end
    end

    // stage 3 logic: minimum score, ties go to the higher index
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            if (r_score[2*k+1] <= r_score[2*k]) begin
                s8[k] = r_score[2*k+1];
                i8[k] = 4'(2*k+1);
            end else begin
                s8[k] = r_score[2*k];
                i8[k] = 4'(2*k);
            end
        end
        for (int k = 0; k < 4; k++) begin
            if (s8[2*k+1] <= s8[2*k]) begin
                s4[k] = s8[2*k+1];
                i4[k] = i8[2*k+1];
            end else begin
                s4[k] = s8[2*k];
                i4[k] = i8[2*k];
            end
        end
        for (int k = 0; k < 2; k++) begin
            if (s4[2*k+1] <= s4[2*k]) begin
                s2[k] = s4[2*k+1];
                i2[k] = i4[2*k+1];
            end else begin
                s2[k] = s4[2*k];
                i2[k] = i4[2*k];
            end
        end
        best = (s2[1] <= s2[0]) ? i2[1] : i2[0];
        n_slice.point16 = best;
        n_slice.point4  = r_q2;
        n_slice.deliver = r_d2;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (load1) r_v1 <= i_valid;
            if (load2) r_v2 <= r_v1;
            if (load3) r_v3 <= r_v2;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (load1) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_q1 <= n_q1;
            r_d1 <= i_item.deliver;
        end
        if (load2) begin
            r_score <= n_score;
            r_q2    <= r_q1;
            r_d2    <= r_d1;
        end
        if (load3) begin
            r_slice <= n_slice;
        end
    end

endmodule

`default_nettype wire

### rtl/qsdd_decoder.sv
// Differential Gray decode and self-synchronizing descrambler.
`timescale 1ns / 1ps
`default_nettype none

module qsdd_decoder import qsdd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_rate_mode,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_slice     i_slice,
    output logic       o_valid,
    input  logic       i_ready,
    output t_bits      o_bits
);

    logic [3:0]        r_prev;
    logic [3:0]        n_prev;
    logic [HIST_W-1:0] r_hist;
    logic [HIST_W-1:0] n_hist;
    logic [3:0]        point;
    logic [2:0]        diff8;
    logic [1:0]        diff4;
    logic [3:0]        raw;
    logic [3:0]        descr;
    logic [2:0]        count;
    logic              update;

    // phase step decode per rate
    always_comb begin
        point  = r_prev;
        diff8  = '0;
        diff4  = '0;
        raw    = '0;
        count  = '0;
        case (i_rate_mode)
            RATE_9600: begin
                point = i_slice.point16;
                diff8 = point[2:0] - r_prev[2:0];
                raw   = {point[3], GRAY8[diff8]};
                count = 3'd4;
            end
            RATE_7200: begin
                point = {1'b0, i_slice.point16[2:0]};
                diff8 = point[2:0] - r_prev[2:0];
                raw   = {GRAY8[diff8], 1'b0};
                count = 3'd3;
            end
            RATE_4800: begin
                point = {2'b00, i_slice.point4};
                diff4 = point[1:0] - r_prev[1:0];
                raw   = {GRAY4[diff4], 2'b00};
                count = 3'd2;
            end
            default: begin
                // unused code: symbol dropped, state kept
                point = r_prev;
                count = '0;
            end
        endcase
        n_prev = point;
    end

    // descramble up to four bits, MSB first
    always_comb begin
        n_hist = r_hist;
        descr  = '0;
        for (int k = 0; k < 4; k++) begin
            if (3'(k) < count) begin
                descr[3-k] = raw[3-k] ^ n_hist[TAP_A] ^ n_hist[TAP_B];
                n_hist     = {n_hist[HIST_W-2:0], raw[3-k]};
            end
        end
    end

    // handshake: training symbols need no room downstream
    assign o_bits.bits  = descr;
    assign o_bits.count = i_slice.deliver ? count : 3'd0;
    assign o_valid      = i_valid && (o_bits.count != 3'd0);
    assign o_ready      = (o_bits.count == 3'd0) || i_ready;
    assign update       = i_valid && o_ready;

    // previous point and descrambler history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_hist <= '0;
        end else if (update) begin
            r_prev <= n_prev;
            r_hist <= n_hist;
        end
    end

endmodule

`default_nettype wire

### rtl/qsdd_serializer.sv
// Output register that sends one symbol's bits one per cycle while i_stall is low.
`timescale 1ns / 1ps
`default_nettype none

module qsdd_serializer import qsdd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_bits     i_bits,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic [3:0] r_bits;
    logic [3:0] n_bits;
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic       take;
    logic       load;

    // reload as the last bit leaves
    assign take    = (r_cnt != 3'd0) && !i_stall;
    assign o_ready = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && !i_stall);
    assign load    = i_valid && o_ready;

    always_comb begin
        n_bits = r_bits;
        n_cnt  = r_cnt;
        if (load) begin
            n_bits = i_bits.bits;
            n_cnt  = i_bits.count;
        end else if (take) begin
            n_bits = {r_bits[2:0], 1'b0};
            n_cnt  = r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
    end

    // output request
    assign o_valid         = r_cnt != 3'd0;
    assign o_item.data_bit = r_bits[3];
    assign o_item.last_bit = r_cnt == 3'd1;

endmodule

`default_nettype wire

### rtl/qam_slicer_diff_descrambler_unit.sv
// Top level of the QAM symbol slicer, differential decoder and descrambler.
// The block takes one equalized Q4.8 symbol per request and returns its
// descrambled bits as one request per bit, with last_bit marking the final
// bit of a symbol (4 bits at 9600, 3 at 7200, 2 at 4800). A symbol can be
// taken every cycle while o_in_stall is low, into a three-stage slicer pipeline
// (grid cell, point scores, nearest-point tree); the serial output register
// then sets the sustained rate, as it sends each symbol's bits one at a time
// (9600, 7200 and 4800 bit/s). Symbols with deliver at 0, or taken while the
// rate code is the unused one, put no bits in it. A symbol's first bit
// leaves through the three slicer stages and then the serial output register.
// rate_mode is written over the config port, which is always ready, and must
// only change while no symbol is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "qam_slicer_diff_descrambler_unit_assert.svh"

module qam_slicer_diff_descrambler_unit import qsdd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // symbol requests
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    // bit requests
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    // rate_mode register
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data
);

    logic [1:0] r_rate_mode;
    logic       slc_ready;
    logic       slc_valid;
    t_slice     slc_out;
    logic       dec_ready;
    logic       dec_valid;
    t_bits      dec_bits;
    logic       ser_ready;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_mode <= RATE_9600;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_rate_mode <= i_cfg_data;
        end
    end

    assign o_in_stall = !slc_ready;

    qsdd_slicer u_slicer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (slc_ready),
        .i_item  (i_in_item),
        .o_valid (slc_valid),
        .i_ready (dec_ready),
        .o_slice (slc_out)
    );

    qsdd_decoder u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rate_mode (r_rate_mode),
        .i_valid     (slc_valid),
        .o_ready     (dec_ready),
        .i_slice     (slc_out),
        .o_valid     (dec_valid),
        .i_ready     (ser_ready),
        .o_bits      (dec_bits)
    );

    qsdd_serializer u_serializer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (ser_ready),
        .i_bits  (dec_bits),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

    // input only backs up behind a busy output register
    `QSDD_ASSERT_NOW(a_stall_needs_output, i_clk, i_rst_n, o_in_stall, o_out_valid,
        "input stalled with idle output")
    // bit count per symbol follows the rate
    `QSDD_ASSERT_NOW(a_count_matches_rate, i_clk, i_rst_n, dec_valid,
        (r_rate_mode == RATE_9600 && dec_bits.count == 3'd4) ||
        (r_rate_mode == RATE_7200 && dec_bits.count == 3'd3) ||
        (r_rate_mode == RATE_4800 && dec_bits.count == 3'd2),
        "bit count does not match rate")
    // a symbol's bits go out without gaps
    `QSDD_ASSERT_NEXT(a_no_gap_in_symbol, i_clk, i_rst_n,
        o_out_valid && !i_out_stall && !o_out_item.last_bit, o_out_valid,
        "gap inside a symbol")

endmodule

`default_nettype wire
